/* rtl/gbss_pkg.sv */
// Shared types and constants for the grid bilinear sample and splat block.
// Holds field widths, opcode and state encodings and parameter defaults.
// No dependencies.
package gbss_pkg;

    // Field widths of the item ports
    localparam int OPC_W  = 2;
    localparam int IDX_W  = 14;
    localparam int POS_W  = 17;
    localparam int DATA_W = 32;

    // Configuration port
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_FRAC_BITS  = 8;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_GRID_WIDTH  = 8'd128;
    localparam logic [CFG_W-1:0] RST_GRID_HEIGHT = 8'd128;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_idx;

    // Item opcodes
    typedef enum logic [OPC_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_SPLAT  = 2'd3
    } t_opcode;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_READ_OUT,
        S_ADDR,
        S_SMP_R00,
        S_SMP_R10,
        S_SMP_R01,
        S_SMP_R11,
        S_SMP_BOT,
        S_SMP_MIX,
        S_SMP_OUT,
        S_SPL_C0,
        S_SPL_C1,
        S_SPL_R00,
        S_SPL_W00,
        S_SPL_R10,
        S_SPL_W10,
        S_SPL_R01,
        S_SPL_W01,
        S_SPL_R11,
        S_SPL_W11
    } t_state;

    // Saturating signed add of two words
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            sat_add = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_add = sum[DATA_W-1:0];
        end
    endfunction

endpackage

/* rtl/gbss_mem.sv */
// Single-port grid word store with a registered read port.
// Depends on gbss_pkg for the word width.
module gbss_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_addr,
    input  logic [gbss_pkg::DATA_W-1:0] i_wdata,
    output logic [gbss_pkg::DATA_W-1:0] o_rdata
);
    import gbss_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write one word, or read one word; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gbss_addr.sv */
// Position clamp and four-cell address generator.
// Depends on gbss_pkg for field and register widths.
module gbss_addr #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int FRAC_BITS  = 8,
    parameter int AW         = 14
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [gbss_pkg::CFG_W-1:0]         i_grid_width,
    input  logic [gbss_pkg::CFG_W-1:0]         i_grid_height,
    input  logic signed [gbss_pkg::POS_W-1:0]  i_x_pos,
    input  logic signed [gbss_pkg::POS_W-1:0]  i_y_pos,
    output logic [3:0][AW-1:0]                 o_cells,
    output logic [FRAC_BITS-1:0]               o_fx,
    output logic [FRAC_BITS-1:0]               o_fy
);
    import gbss_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HH   = $clog2(MAX_HEIGHT + 1);
    localparam int XW   = WW + FRAC_BITS;
    localparam int YW   = HH + FRAC_BITS;
    localparam int WCW  = (CFG_W > WW) ? CFG_W : WW;
    localparam int HCW  = (CFG_W > HH) ? CFG_W : HH;
    localparam int XCW  = ((POS_W > XW) ? POS_W : XW) + 1;
    localparam int YCW  = ((POS_W > YW) ? POS_W : YW) + 1;
    localparam int PRW  = WW + HH + 1;

    logic [WW-1:0]         w_w;
    logic [HH-1:0]         w_h;
    logic [XW-1:0]         w_xhi;
    logic [YW-1:0]         w_yhi;
    logic signed [XCW-1:0] w_xs;
    logic signed [XCW-1:0] w_xhs;
    logic signed [YCW-1:0] w_ys;
    logic signed [YCW-1:0] w_yhs;
    logic [XW-1:0]         w_xc;
    logic [YW-1:0]         w_yc;
    logic [PRW-1:0]        w_lin;
    logic [AW-1:0]         w_p00;
    logic [3:0][AW-1:0]    r_cells;
    logic [FRAC_BITS-1:0]  r_fx;
    logic [FRAC_BITS-1:0]  r_fy;

    // Limit the configured sizes to the store
    always_comb begin
        if (WCW'(i_grid_width) < WCW'(2)) begin
            w_w = WW'(2);
        end else if (WCW'(i_grid_width) > WCW'(MAX_WIDTH)) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(i_grid_width);
        end
        if (HCW'(i_grid_height) < HCW'(2)) begin
            w_h = HH'(2);
        end else if (HCW'(i_grid_height) > HCW'(MAX_HEIGHT)) begin
            w_h = HH'(MAX_HEIGHT);
        end else begin
            w_h = HH'(i_grid_height);
        end
    end

    // Clamp the position one LSB short of the last column and row
    always_comb begin
        w_xhi = {w_w - WW'(1), {FRAC_BITS{1'b0}}} - XW'(1);
        w_yhi = {w_h - HH'(1), {FRAC_BITS{1'b0}}} - YW'(1);
        w_xs  = XCW'(i_x_pos);
        w_ys  = YCW'(i_y_pos);
        w_xhs = XCW'({1'b0, w_xhi});
        w_yhs = YCW'({1'b0, w_yhi});
        if (w_xs < 0) begin
            w_xc = '0;
        end else if (w_xs > w_xhs) begin
            w_xc = w_xhi;
        end else begin
            w_xc = w_xs[XW-1:0];
        end
        if (w_ys < 0) begin
            w_yc = '0;
        end else if (w_ys > w_yhs) begin
            w_yc = w_yhi;
        end else begin
            w_yc = w_ys[YW-1:0];
        end
    end

    // Row-major index of the upper left cell
    always_comb begin
        w_lin = PRW'(w_yc[YW-1:FRAC_BITS]) * PRW'(w_w) + PRW'(w_xc[XW-1:FRAC_BITS]);
        w_p00 = w_lin[AW-1:0];
    end

    // Register the four cells and the fractions
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cells[0] <= w_p00;
            r_cells[1] <= w_p00 + AW'(1);
            r_cells[2] <= w_p00 + AW'(w_w);
            r_cells[3] <= w_p00 + AW'(w_w) + AW'(1);
            r_fx       <= w_xc[FRAC_BITS-1:0];
            r_fy       <= w_yc[FRAC_BITS-1:0];
        end
    end

    assign o_cells = r_cells;
    assign o_fx    = r_fx;
    assign o_fy    = r_fy;

endmodule

/* rtl/gbss_mac.sv */
// Shared weighted multiply unit: out = base + floor(diff * weight / 2^FRAC_BITS).
// Depends on gbss_pkg for the word width.
module gbss_mac #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [gbss_pkg::DATA_W-1:0]  i_base,
    input  logic signed [gbss_pkg::DATA_W:0]    i_diff,
    input  logic [FRAC_BITS:0]                  i_wgt,
    output logic signed [gbss_pkg::DATA_W-1:0]  o_result
);
    import gbss_pkg::*;

    localparam int PW = DATA_W + 1 + FRAC_BITS + 2;

    logic signed [PW-1:0]     w_prod;
    logic signed [PW-1:0]     w_sum;
    logic signed [DATA_W-1:0] r_result;

    // Multiply, floor by arithmetic shift, add the base
    always_comb begin
        w_prod = i_diff * $signed({1'b0, i_wgt});
        w_sum  = (w_prod >>> FRAC_BITS) + PW'(i_base);
    end

    // Hold the result until the next enabled step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= w_sum[DATA_W-1:0];
        end
    end

    assign o_result = r_result;

endmodule

/* rtl/grid_bilinear_sample_splat_top.sv */
// Top level of the grid bilinear sample and splat block: sequencer,
// grid store, address generator and shared weighted multiply unit.
// Depends on gbss_pkg, gbss_mem, gbss_addr and gbss_mac.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall   | opcode, index, x, y, data
//   out     | output    | o_out_valid / i_out_stall | result_value
//   cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item at a time, gated by the sequencer over the single-port grid store.
// Each item runs through its own sequencer states before the next accept; sample and
// splat visit the four cells in turn over the one-access-per-cycle store port.
// A finished result waits in the output register; the next item is taken meanwhile.
// A stalled output holds the sequencer only at the step that delivers a result.
// Reset clears control and sizes to 128 by 128; the store is not cleared.
module grid_bilinear_sample_splat_top #(
    parameter int MAX_WIDTH  = gbss_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gbss_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = gbss_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [gbss_pkg::OPC_W-1:0]          i_opcode,
    input  logic [gbss_pkg::IDX_W-1:0]          i_cell_index,
    input  logic signed [gbss_pkg::POS_W-1:0]   i_x_pos,
    input  logic signed [gbss_pkg::POS_W-1:0]   i_y_pos,
    input  logic signed [gbss_pkg::DATA_W-1:0]  i_data_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [gbss_pkg::DATA_W-1:0]  o_result_value,
    input  logic                                i_cfg_we,
    input  logic [gbss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gbss_pkg::CFG_W-1:0]          i_cfg_data
);
    import gbss_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IRW   = ((IDX_W > AW) ? IDX_W : AW) + 1;
    localparam int WGT_W = FRAC_BITS + 1;
    localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    t_state                   r_state, n_state;
    t_opcode                  r_op;
    logic [IDX_W-1:0]         r_idx;
    logic signed [POS_W-1:0]  r_x;
    logic signed [POS_W-1:0]  r_y;
    logic signed [DATA_W-1:0] r_val;
    logic [CFG_W-1:0]         r_cfg_w;
    logic [CFG_W-1:0]         r_cfg_h;
    logic [DATA_W-1:0]        r_a, n_a;
    logic [DATA_W-1:0]        r_top, n_top;
    logic [DATA_W-1:0]        r_c0, n_c0;
    logic [DATA_W-1:0]        r_c1, n_c1;
    logic                     r_out_valid, n_out_valid;
    logic [DATA_W-1:0]        r_result, n_result;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_in_range;
    logic                     w_addr_en;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic [AW-1:0]            w_mem_addr;
    logic [DATA_W-1:0]        w_mem_wdata;
    logic [DATA_W-1:0]        w_rdata;
    logic                     w_mac_en;
    logic signed [DATA_W-1:0] w_mac_base;
    logic signed [DATA_W:0]   w_mac_diff;
    logic [WGT_W-1:0]         w_mac_wgt;
    logic signed [DATA_W-1:0] w_mac_out;
    logic [3:0][AW-1:0]       w_cells;
    logic [FRAC_BITS-1:0]     w_fx;
    logic [FRAC_BITS-1:0]     w_fy;
    logic [WGT_W-1:0]         w_wfx;
    logic [WGT_W-1:0]         w_wfx_inv;
    logic [WGT_W-1:0]         w_wfy;
    logic [WGT_W-1:0]         w_wfy_inv;

    // Handshake terms
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_in_range  = IRW'(r_idx) < IRW'(DEPTH);

    // Weights of the two neighbors on each axis
    assign w_wfx     = {1'b0, w_fx};
    assign w_wfy     = {1'b0, w_fy};
    assign w_wfx_inv = WGT_ONE - w_wfx;
    assign w_wfy_inv = WGT_ONE - w_wfy;

    gbss_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    gbss_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .AW         (AW)
    ) u_addr (
        .i_clk         (i_clk),
        .i_en          (w_addr_en),
        .i_grid_width  (r_cfg_w),
        .i_grid_height (r_cfg_h),
        .i_x_pos       (r_x),
        .i_y_pos       (r_y),
        .o_cells       (w_cells),
        .o_fx          (w_fx),
        .o_fy          (w_fy)
    );

    gbss_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_en     (w_mac_en),
        .i_base   (w_mac_base),
        .i_diff   (w_mac_diff),
        .i_wgt    (w_mac_wgt),
        .o_result (w_mac_out)
    );

    // Sequencer: next state, store and multiply controls, staging values
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_top       = r_top;
        n_c0        = r_c0;
        n_c1        = r_c1;
        n_out_valid = r_out_valid && i_out_stall;
        n_result    = r_result;
        w_addr_en   = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = w_cells[0];
        w_mem_wdata = sat_add(w_rdata, w_mac_out);
        w_mac_en    = 1'b0;
        w_mac_base  = '0;
        w_mac_diff  = (DATA_W+1)'(r_val);
        w_mac_wgt   = w_wfx_inv;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_LOAD:   n_state = S_LOAD;
                        OP_READ:   n_state = S_READ;
                        OP_SAMPLE: n_state = S_ADDR;
                        OP_SPLAT:  n_state = S_ADDR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            // Load and read go straight to the indexed word
            S_LOAD: begin
                w_mem_addr  = AW'(r_idx);
                w_mem_wdata = r_val;
                w_mem_we    = w_in_range;
                n_state     = S_IDLE;
            end
            S_READ: begin
                w_mem_addr = AW'(r_idx);
                w_mem_re   = w_in_range;
                n_state    = S_READ_OUT;
            end
            S_READ_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_result    = w_in_range ? w_rdata : '0;
                    n_state     = S_IDLE;
                end
            end
            S_ADDR: begin
                w_addr_en = 1'b1;
                n_state   = (r_op == OP_SAMPLE) ? S_SMP_R00 : S_SPL_C0;
            end
            // Sample: fetch four cells, blend top row, bottom row, then rows
            S_SMP_R00: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[0];
                n_state    = S_SMP_R10;
            end
            S_SMP_R10: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[1];
                n_a        = w_rdata;
                n_state    = S_SMP_R01;
            end
            S_SMP_R01: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[2];
                w_mac_en   = 1'b1;
                w_mac_base = $signed(r_a);
                w_mac_diff = $signed({w_rdata[DATA_W-1], w_rdata})
                           - $signed({r_a[DATA_W-1], r_a});
                w_mac_wgt  = w_wfx;
                n_state    = S_SMP_R11;
            end
            S_SMP_R11: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[3];
                n_a        = w_rdata;
                n_top      = w_mac_out;
                n_state    = S_SMP_BOT;
            end
            S_SMP_BOT: begin
                w_mac_en   = 1'b1;
                w_mac_base = $signed(r_a);
                w_mac_diff = $signed({w_rdata[DATA_W-1], w_rdata})
                           - $signed({r_a[DATA_W-1], r_a});
                w_mac_wgt  = w_wfx;
                n_state    = S_SMP_MIX;
            end
            S_SMP_MIX: begin
                w_mac_en   = 1'b1;
                w_mac_base = $signed(r_top);
                w_mac_diff = $signed({w_mac_out[DATA_W-1], w_mac_out})
                           - $signed({r_top[DATA_W-1], r_top});
                w_mac_wgt  = w_wfy;
                n_state    = S_SMP_OUT;
            end
            S_SMP_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_result    = w_mac_out;
                    n_state     = S_IDLE;
                end
            end
            // Splat: split the amount by column, then add each part per cell
            S_SPL_C0: begin
                w_mac_en  = 1'b1;
                w_mac_wgt = w_wfx_inv;
                n_state   = S_SPL_C1;
            end
            S_SPL_C1: begin
                n_c0      = w_mac_out;
                w_mac_en  = 1'b1;
                w_mac_wgt = w_wfx;
                n_state   = S_SPL_R00;
            end
            S_SPL_R00: begin
                n_c1       = w_mac_out;
                w_mac_en   = 1'b1;
                w_mac_diff = (DATA_W+1)'($signed(r_c0));
                w_mac_wgt  = w_wfy_inv;
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[0];
                n_state    = S_SPL_W00;
            end
            S_SPL_W00: begin
                w_mem_we   = 1'b1;
                w_mem_addr = w_cells[0];
                w_mac_en   = 1'b1;
                w_mac_diff = (DATA_W+1)'($signed(r_c1));
                w_mac_wgt  = w_wfy_inv;
                n_state    = S_SPL_R10;
            end
            S_SPL_R10: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[1];
                n_state    = S_SPL_W10;
            end
            S_SPL_W10: begin
                w_mem_we   = 1'b1;
                w_mem_addr = w_cells[1];
                w_mac_en   = 1'b1;
                w_mac_diff = (DATA_W+1)'($signed(r_c0));
                w_mac_wgt  = w_wfy;
                n_state    = S_SPL_R01;
            end
            S_SPL_R01: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[2];
                n_state    = S_SPL_W01;
            end
            S_SPL_W01: begin
                w_mem_we   = 1'b1;
                w_mem_addr = w_cells[2];
                w_mac_en   = 1'b1;
                w_mac_diff = (DATA_W+1)'($signed(r_c1));
                w_mac_wgt  = w_wfy;
                n_state    = S_SPL_R11;
            end
            S_SPL_R11: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_cells[3];
                n_state    = S_SPL_W11;
            end
            S_SPL_W11: begin
                w_mem_we   = 1'b1;
                w_mem_addr = w_cells[3];
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, output flag and size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_w     <= RST_GRID_WIDTH;
            r_cfg_h     <= RST_GRID_HEIGHT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_GRID_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_GRID_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Capture the item and advance staging values
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_opcode'(i_opcode);
            r_idx <= i_cell_index;
            r_x   <= i_x_pos;
            r_y   <= i_y_pos;
            r_val <= i_data_value;
        end
        r_a      <= n_a;
        r_top    <= n_top;
        r_c0     <= n_c0;
        r_c1     <= n_c1;
        r_result <= n_result;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;

endmodule

/* rtl/gbss_checker.sv */
// Port-level checks for the grid bilinear sample and splat top level,
// bound to it below. Depends on gbss_pkg for the word width.
module gbss_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [gbss_pkg::DATA_W-1:0] o_result_value
);
    import gbss_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_result_value))
        else $error("stalled result changed");

    // An accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted twice in a row");

    // The first step after an accept never delivers a result
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##1 !$rose(o_out_valid))
        else $error("result appeared too early");

    // Reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind grid_bilinear_sample_splat_top gbss_checker u_gbss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value)
);
